// ----- design/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ----- design/dlsc_pkg.sv -----
package dlsc_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int NUM_BOARDS_DEF = 8;
   localparam int DIGITS_DEF = 8;

   localparam logic [2:0] REQ_WRITE = 3'd0;
   localparam logic [2:0] REQ_DRAW  = 3'd1;
   localparam logic [2:0] REQ_PUSH  = 3'd2;
   localparam logic [2:0] REQ_POP   = 3'd3;
   localparam logic [2:0] REQ_ALPHA = 3'd4;

   localparam logic [1:0] KIND_CELL  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_EXEC, ST_UNLINK, ST_WALK, ST_PAINT, ST_DONE, ST_OUT
   } state_type;

   typedef struct packed {
      logic check;
      logic exec;
      logic unlink;
      logic walk_start;
      logic walk;
      logic paint;
      logic finish;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic need_walk;
      logic unlink_done;
      logic walk_done;
      logic paint_done;
      logic out_taken;
      logic out_more;
   } sts_type;
endpackage

// ----- design/display_layer_stack_compositor.sv -----
// Layer stack compositor: one request is in work at a time and its results drain
// before the next is taken. A request passes through check and execute; a pop then
// searches its stack layer by layer to unlink the slot, the stack is walked layer
// by layer where needed, the listed cells are read from the digit store, the request
// finishes, the result beats are sent as the receiver takes them, and the block
// goes idle before the next request is taken.
module display_layer_stack_compositor
   import dlsc_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int NUM_BOARDS_P = NUM_BOARDS_DEF,
   parameter int DIGITS_PER_BOARD = DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type
   input  logic [2:0]  req_tuser,
   // slot, board, digit, segments, alpha_bits
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind
   output logic [1:0]  rsp_tuser,
   // out_board, out_digit, out_segments, status
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);
   cmd_type cmd;
   sts_type sts;
   logic idle;
   logic [2:0] ob, od;
   logic [7:0] os;
   logic st;

   assign req_tready = idle;

   dlsc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid && idle),
      .sts(sts), .cmd(cmd), .idle(idle)
   );

   dlsc_datapath #(
      .NUM_SLOTS(NUM_SLOTS), .NUM_BOARDS_P(NUM_BOARDS_P),
      .DIGITS_PER_BOARD(DIGITS_PER_BOARD)
   ) u_dp (
      .clock(clock), .reset(reset), .load(req_tvalid && idle),
      .in_type(req_tuser), .in_slot(req_tdata[3:0]), .in_board(req_tdata[6:4]),
      .in_digit(req_tdata[9:7]), .in_segments(req_tdata[17:10]),
      .in_alpha(req_tdata[25:18]),
      .cmd(cmd), .sts(sts), .out_ready(rsp_tready), .out_valid(rsp_tvalid),
      .out_kind(rsp_tuser), .out_board(ob), .out_digit(od), .out_segments(os),
      .out_status(st), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, st, os, od, ob};
endmodule

// ----- design/dlsc_ctrl.sv -----
module dlsc_ctrl
   import dlsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    idle
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.reject) state_in = ST_DONE;
            else state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_UNLINK;
         ST_UNLINK: begin
            if (sts.unlink_done) begin
               if (sts.need_walk) state_in = ST_WALK;
               else state_in = ST_DONE;
            end
         end
         ST_WALK: if (sts.walk_done) state_in = ST_PAINT;
         ST_PAINT: if (sts.paint_done) state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT: if (sts.out_taken && !sts.out_more) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_CHECK: cmd.check = 1'b1;
         ST_EXEC: cmd.exec = 1'b1;
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            cmd.walk_start = sts.unlink_done;
         end
         ST_WALK: cmd.walk = 1'b1;
         ST_PAINT: cmd.paint = 1'b1;
         ST_DONE: cmd.finish = 1'b1;
         ST_OUT: cmd.send = 1'b1;
         default: idle = 1'b0;
      endcase
   end
endmodule

// ----- design/dlsc_datapath.sv -----
module dlsc_datapath
   import dlsc_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int NUM_BOARDS_P = NUM_BOARDS_DEF,
   parameter int DIGITS_PER_BOARD = DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [2:0] in_type,
   input  logic [3:0] in_slot,
   input  logic [2:0] in_board,
   input  logic [2:0] in_digit,
   input  logic [7:0] in_segments,
   input  logic [7:0] in_alpha,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic       out_ready,
   output logic       out_valid,
   output logic [1:0] out_kind,
   output logic [2:0] out_board,
   output logic [2:0] out_digit,
   output logic [7:0] out_segments,
   output logic       out_status,
   output logic       out_last
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int BW = (NUM_BOARDS_P > 1) ? $clog2(NUM_BOARDS_P) : 1;
   localparam int DEPTH = NUM_SLOTS * 8;

   logic [7:0] mem [DEPTH];
   logic [7:0] alpha_ff [NUM_SLOTS];
   logic [7:0] vis_ff [NUM_SLOTS];
   logic [BW-1:0] sboard_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] stacked_ff, hasb_ff, dvalid_ff [8];
   logic [SW-1:0] below_ff [NUM_SLOTS];
   logic [SW-1:0] top_ff [NUM_BOARDS_P];
   logic [NUM_BOARDS_P-1:0] occ_ff;

   logic [2:0] typ_ff;
   logic [3:0] rslot_ff;
   logic [2:0] rboard_ff, rdigit_ff;
   logic [7:0] rseg_ff, ralpha_ff;
   logic rej_ff, redraw_ff;
   logic [SW-1:0] cur_ff, prev_ff;
   logic [BW-1:0] bb_ff;
   logic [7:0] left_ff;
   logic [4:0] wcnt_ff;
   logic [4:0] ucnt_ff;

   // paint list: slot, board and digit per cell
   logic [SW-1:0] pslot_ff [8];
   logic [BW-1:0] pboard_ff [8];
   logic [2:0] pdig_ff [8];
   logic [3:0] pcnt_ff, pidx_ff;
   logic [3:0] ocnt_ff;
   logic [1:0] okind_ff [8];
   logic [2:0] oboard_ff [8];
   logic [2:0] odig_ff [8];
   logic [7:0] oseg_ff [8];
   logic ostat_ff;
   logic [3:0] osend_ff;
   logic [7:0] rd_ff;
   logic rd_pend_ff;

   wire [SW-1:0] s = rslot_ff[SW-1:0];
   wire slot_ok = (32'(rslot_ff) < NUM_SLOTS);
   wire [BW-1:0] b = rboard_ff[BW-1:0];
   wire [7:0] dmask = 8'h80 >> rdigit_ff;

   // walk step lists visible cells into the paint list
   logic [7:0] vis_now;
   assign vis_now = left_ff & alpha_ff[cur_ff];

   always_ff @(posedge clock) begin
      if (load) begin
         typ_ff <= in_type; rslot_ff <= in_slot; rboard_ff <= in_board;
         rdigit_ff <= in_digit; rseg_ff <= in_segments; ralpha_ff <= in_alpha;
      end
      if (cmd.check) begin
         rej_ff <= !(typ_ff <= REQ_ALPHA) || !slot_ok
            || (typ_ff == REQ_WRITE && 32'(rdigit_ff) >= DIGITS_PER_BOARD)
            || (typ_ff == REQ_PUSH && (stacked_ff[s] || 32'(rboard_ff) >= NUM_BOARDS_P))
            || (typ_ff == REQ_POP && !stacked_ff[s]);
      end
   end

   always_comb begin
      sts = '0;
      sts.reject = !(typ_ff <= REQ_ALPHA) || !slot_ok
         || (typ_ff == REQ_WRITE && 32'(rdigit_ff) >= DIGITS_PER_BOARD)
         || (typ_ff == REQ_PUSH && (stacked_ff[s] || 32'(rboard_ff) >= NUM_BOARDS_P))
         || (typ_ff == REQ_POP && !stacked_ff[s]);
      sts.need_walk = (typ_ff == REQ_PUSH)
         || ((typ_ff == REQ_DRAW || typ_ff == REQ_ALPHA) && stacked_ff[s])
         || (typ_ff == REQ_POP && (top_ff[bb_ff] != s || hasb_ff[s]));
      sts.unlink_done = (typ_ff != REQ_POP)
         || ucnt_ff == 5'(NUM_SLOTS) || top_ff[bb_ff] == s || !hasb_ff[prev_ff]
         || below_ff[prev_ff] == s;
      sts.walk_done = (typ_ff == REQ_DRAW) || !hasb_ff[cur_ff]
         || wcnt_ff == 5'(NUM_SLOTS - 1);
      sts.paint_done = (pidx_ff == pcnt_ff) && !rd_pend_ff;
      sts.out_taken = out_valid && out_ready;
      sts.out_more = (osend_ff + 4'd1) < ocnt_ff;
   end

   assign out_valid = cmd.send;
   assign out_kind = okind_ff[osend_ff[2:0]];
   assign out_board = oboard_ff[osend_ff[2:0]];
   assign out_digit = odig_ff[osend_ff[2:0]];
   assign out_segments = oseg_ff[osend_ff[2:0]];
   assign out_status = ostat_ff;
   assign out_last = !sts.out_more;

   logic [$clog2(DEPTH)-1:0] raddr;
   assign raddr = {pslot_ff[pidx_ff[2:0]], pdig_ff[pidx_ff[2:0]]};

   always_ff @(posedge clock) begin
      if (cmd.exec && typ_ff == REQ_WRITE) mem[{s, rdigit_ff}] <= rseg_ff;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stacked_ff <= '0; hasb_ff <= '0; occ_ff <= '0;
         for (int i = 0; i < 8; i++) dvalid_ff[i] <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            alpha_ff[i] <= 8'hff; vis_ff[i] <= '0; sboard_ff[i] <= '0; below_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_BOARDS_P; i++) top_ff[i] <= '0;
         pcnt_ff <= '0; pidx_ff <= '0; ocnt_ff <= '0; osend_ff <= '0; rd_pend_ff <= 1'b0;
      end else begin
         if (cmd.check) begin
            pcnt_ff <= '0; pidx_ff <= '0; ocnt_ff <= '0; osend_ff <= '0;
            rd_pend_ff <= 1'b0; ucnt_ff <= '0; ostat_ff <= 1'b0;
            bb_ff <= sboard_ff[s];
            prev_ff <= top_ff[sboard_ff[s]];
            cur_ff <= s;
         end
         if (cmd.exec) begin
            case (typ_ff)
               REQ_WRITE: begin
                  dvalid_ff[rdigit_ff][s] <= 1'b1;
                  if (stacked_ff[s] && (vis_ff[s] & dmask) != 8'h00) begin
                     okind_ff[0] <= KIND_CELL; oboard_ff[0] <= 3'(sboard_ff[s]);
                     odig_ff[0] <= rdigit_ff; oseg_ff[0] <= rseg_ff; ocnt_ff <= 4'd1;
                  end
               end
               REQ_PUSH: begin
                  sboard_ff[s] <= b;
                  hasb_ff[s] <= occ_ff[b];
                  below_ff[s] <= occ_ff[b] ? top_ff[b] : '0;
                  top_ff[b] <= s; occ_ff[b] <= 1'b1; stacked_ff[s] <= 1'b1;
                  bb_ff <= b;
               end
               REQ_ALPHA: alpha_ff[s] <= ralpha_ff;
               default: ;
            endcase
         end
         if (cmd.unlink && typ_ff == REQ_POP) begin
            if (top_ff[bb_ff] == s) begin
               if (hasb_ff[s]) top_ff[bb_ff] <= below_ff[s];
               else occ_ff[bb_ff] <= 1'b0;
            end else if (hasb_ff[prev_ff] && below_ff[prev_ff] == s
                         && ucnt_ff != 5'(NUM_SLOTS)) begin
               below_ff[prev_ff] <= below_ff[s];
               hasb_ff[prev_ff] <= hasb_ff[s];
            end else begin
               prev_ff <= below_ff[prev_ff];
               ucnt_ff <= ucnt_ff + 5'd1;
            end
         end
         if (cmd.walk_start) begin
            left_ff <= 8'hff; wcnt_ff <= '0;
            case (typ_ff)
               REQ_DRAW: begin
                  redraw_ff <= 1'b1; cur_ff <= s;
               end
               REQ_PUSH: begin
                  redraw_ff <= 1'b0; cur_ff <= s;
               end
               REQ_POP: begin
                  stacked_ff[s] <= 1'b0; hasb_ff[s] <= 1'b0; below_ff[s] <= '0;
                  vis_ff[s] <= '0; sboard_ff[s] <= '0;
                  redraw_ff <= 1'b1;
                  cur_ff <= (top_ff[bb_ff] == s) ? below_ff[s] : top_ff[bb_ff];
                  if (top_ff[bb_ff] == s && !hasb_ff[s]) begin
                     okind_ff[0] <= KIND_CLEAR; oboard_ff[0] <= 3'(bb_ff);
                     odig_ff[0] <= '0; oseg_ff[0] <= '0; ocnt_ff <= 4'd1;
                  end
               end
               REQ_ALPHA: begin
                  redraw_ff <= 1'b1;
                  cur_ff <= top_ff[bb_ff];
               end
               default: ;
            endcase
         end
         if (cmd.walk) begin
            logic [3:0] c;
            logic [7:0] m;
            c = pcnt_ff;
            m = (typ_ff == REQ_DRAW) ? vis_ff[cur_ff] : vis_now;
            if (typ_ff != REQ_DRAW) begin
               vis_ff[cur_ff] <= vis_now;
               left_ff <= left_ff & ~alpha_ff[cur_ff];
            end
            if ((redraw_ff || cur_ff == s) && stacked_ff[cur_ff]) begin
               for (int i = 0; i < DIGITS_PER_BOARD; i++) begin
                  if (m[7-i] && c < 4'd8) begin
                     pslot_ff[c[2:0]] <= cur_ff;
                     pboard_ff[c[2:0]] <= sboard_ff[cur_ff];
                     pdig_ff[c[2:0]] <= 3'(i);
                     c = c + 4'd1;
                  end
               end
            end
            pcnt_ff <= c;
            wcnt_ff <= wcnt_ff + 5'd1;
            cur_ff <= below_ff[cur_ff];
         end
         if (cmd.paint) begin
            if (rd_pend_ff) begin
               okind_ff[ocnt_ff[2:0]] <= KIND_CELL;
               oboard_ff[ocnt_ff[2:0]] <= 3'(pboard_ff[pidx_ff[2:0] - 3'd1]);
               odig_ff[ocnt_ff[2:0]] <= pdig_ff[pidx_ff[2:0] - 3'd1];
               oseg_ff[ocnt_ff[2:0]] <=
                  dvalid_ff[pdig_ff[pidx_ff[2:0] - 3'd1]][pslot_ff[pidx_ff[2:0] - 3'd1]]
                  ? rd_ff : 8'h00;
               ocnt_ff <= ocnt_ff + 4'd1;
            end
            rd_pend_ff <= pidx_ff != pcnt_ff;
            if (pidx_ff != pcnt_ff) pidx_ff <= pidx_ff + 4'd1;
         end
         if (cmd.finish && (rej_ff || ocnt_ff == 4'd0)) begin
            okind_ff[0] <= KIND_ACK; oboard_ff[0] <= '0; odig_ff[0] <= '0;
            oseg_ff[0] <= '0; ocnt_ff <= 4'd1; ostat_ff <= rej_ff;
         end
         if (sts.out_taken) osend_ff <= osend_ff + 4'd1;
      end
   end
endmodule

// ----- design/dlsc_checker.sv -----
`include "assert_macros.svh"
module dlsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   `ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_tvalid |-> !req_tready)
   `ASSERT_IMPL(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))
   `ASSERT_IMPL(a_rej_last, clock, reset, rsp_tvalid && rsp_tdata[14] |-> rsp_tlast)
   `ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_tvalid)
endmodule

bind display_layer_stack_compositor dlsc_checker u_chk (.*);

// ----- sim/display_layer_stack_compositor_test.sv -----
module display_layer_stack_compositor_test
   import dlsc_pkg::*;
();

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] slot;
      logic [2:0] board;
      logic [2:0] digit;
      logic [7:0] segments;
      logic [7:0] alpha_bits;
   } request_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] out_board;
      logic [2:0] out_digit;
      logic [7:0] out_segments;
      logic       status;
      logic       last;
   } cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2:0] req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [1:0] rsp_tuser;
   logic [15:0] rsp_tdata;
   logic rsp_tlast;

   display_layer_stack_compositor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // shadow state
   logic [7:0] m_digits [0:127];
   logic [7:0] m_alpha [0:15];
   logic [7:0] m_visible [0:15];
   logic [2:0] m_board [0:15];
   logic       m_stacked [0:15];
   logic [3:0] m_below [0:15];
   logic       m_has_below [0:15];
   logic [3:0] m_top [0:7];
   logic       m_occupied [0:7];

   request_type pending_requests[$];
   request_type drv_req;
   cell_type expected_cells[$];
   cell_type step_cells[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_sender = 0;
   int quiet_cycles = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void add_cell(input logic [1:0] k, input logic [2:0] b,
                                    input logic [2:0] d, input logic [7:0] sg,
                                    input logic st);
      cell_type c;
      if (step_cells.size() >= 8) return;
      c = '{k, b, d, sg, st, 1'b0};
      step_cells.push_back(c);
   endfunction

   function automatic void paint_slot(input logic [3:0] s);
      if (!m_stacked[s]) return;
      for (int i = 0; i < 8; i++)
         if (m_visible[s][7-i]) add_cell(KIND_CELL, m_board[s], i[2:0], m_digits[{s, i[2:0]}], 0);
   endfunction

   function automatic void restack(input logic [3:0] s0, input bit redraw);
      logic [7:0] left;
      logic [3:0] s;
      left = 8'hff;
      s = s0;
      for (int n = 0; n < 16; n++) begin
         m_visible[s] = left & m_alpha[s];
         left &= ~m_alpha[s];
         if (redraw) paint_slot(s);
         if (!m_has_below[s]) break;
         s = m_below[s];
      end
   endfunction

   function automatic void composite(input request_type r);
      logic [3:0] s;
      logic [2:0] bb;
      logic [3:0] p;
      cell_type c;
      s = r.slot;
      step_cells.delete();
      if (r.req_type > REQ_ALPHA || (r.req_type == REQ_PUSH && m_stacked[s]) ||
          (r.req_type == REQ_POP && !m_stacked[s])) begin
         add_cell(KIND_ACK, 0, 0, 0, 1);
      end else begin
         case (r.req_type)
            REQ_WRITE: begin
               m_digits[{s, r.digit}] = r.segments;
               if (m_stacked[s] && m_visible[s][7-r.digit])
                  add_cell(KIND_CELL, m_board[s], r.digit, r.segments, 0);
            end
            REQ_DRAW: paint_slot(s);
            REQ_PUSH: begin
               m_board[s] = r.board;
               m_has_below[s] = m_occupied[r.board];
               m_below[s] = m_occupied[r.board] ? m_top[r.board] : 4'd0;
               m_top[r.board] = s;
               m_occupied[r.board] = 1;
               m_stacked[s] = 1;
               restack(s, 0);
               paint_slot(s);
            end
            REQ_POP: begin
               bb = m_board[s];
               if (m_top[bb] == s) begin
                  if (m_has_below[s]) m_top[bb] = m_below[s];
                  else m_occupied[bb] = 0;
               end else begin
                  p = m_top[bb];
                  for (int n = 0; n < 16; n++) begin
                     if (!m_has_below[p]) break;
                     if (m_below[p] == s) begin
                        m_below[p] = m_below[s];
                        m_has_below[p] = m_has_below[s];
                        break;
                     end
                     p = m_below[p];
                  end
               end
               m_stacked[s] = 0;
               m_has_below[s] = 0;
               m_below[s] = 0;
               m_visible[s] = 0;
               m_board[s] = 0;
               if (m_occupied[bb]) restack(m_top[bb], 1);
               else add_cell(KIND_CLEAR, bb, 0, 0, 0);
            end
            default: begin
               m_alpha[s] = r.alpha_bits;
               if (m_stacked[s]) restack(m_top[m_board[s]], 1);
            end
         endcase
         if (step_cells.size() == 0) add_cell(KIND_ACK, 0, 0, 0, 0);
      end
      c = step_cells[$];
      c.last = 1;
      step_cells[$] = c;
      foreach (step_cells[i]) expected_cells.push_back(step_cells[i]);
   endfunction

   function automatic request_type make_req(input logic [2:0] t, input logic [3:0] s,
                                            input logic [2:0] b, input logic [2:0] d,
                                            input logic [7:0] sg, input logic [7:0] a);
      request_type r;
      r = '{t, s, b, d, sg, a};
      return r;
   endfunction

   function automatic request_type rand_req();
      int w;
      w = $urandom_range(0, 99);
      return make_req(w < 25 ? REQ_WRITE : w < 35 ? REQ_DRAW : w < 60 ? REQ_PUSH :
                      w < 80 ? REQ_POP : w < 97 ? REQ_ALPHA : 3'($urandom_range(5, 7)),
                      4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && req_tready) begin
         composite(drv_req);
         if (pending_requests.size() != 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_requests.pop_front();
            drv_req <= nxt;
            req_tuser <= nxt.req_type;
            req_tdata <= {6'd0, nxt.alpha_bits, nxt.segments, nxt.digit, nxt.board, nxt.slot};
         end else begin
            req_tvalid <= 0;
         end
      end else if (!req_tvalid && pending_requests.size() != 0 && !hold_sender &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
         nxt = pending_requests.pop_front();
         req_tvalid <= 1;
         drv_req <= nxt;
         req_tuser <= nxt.req_type;
         req_tdata <= {6'd0, nxt.alpha_bits, nxt.segments, nxt.digit, nxt.board, nxt.slot};
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      cell_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[2:0], rsp_tdata[5:3], rsp_tdata[13:6],
                 rsp_tdata[14], rsp_tlast};
         if (expected_cells.size() == 0) begin
            report($sformatf("unexpected response %h", got));
         end else begin
            want = expected_cells.pop_front();
            if (got.kind !== want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.out_board !== want.out_board) report("board");
            if (got.out_digit !== want.out_digit) report("digit");
            if (got.out_segments !== want.out_segments) report("segments");
            if (got.status !== want.status) report("status");
            if (got.last !== want.last) report("last");
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && quiet_cycles > 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_cells.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int n;
      for (int i = 0; i < 128; i++) m_digits[i] = 0;
      for (int i = 0; i < 16; i++) begin
         m_alpha[i] = 8'hff; m_visible[i] = 0; m_board[i] = 0;
         m_stacked[i] = 0; m_below[i] = 0; m_has_below[i] = 0;
      end
      for (int i = 0; i < 8; i++) begin
         m_top[i] = 0; m_occupied[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed
      pending_requests.push_back(make_req(REQ_WRITE, 0, 0, 0, 8'hff, 0));
      pending_requests.push_back(make_req(REQ_WRITE, 0, 0, 7, 8'h01, 0));
      pending_requests.push_back(make_req(REQ_DRAW, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_POP, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_PUSH, 0, 7, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_PUSH, 0, 3, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_ALPHA, 15, 0, 0, 0, 8'h0f));
      pending_requests.push_back(make_req(REQ_WRITE, 15, 0, 4, 8'ha5, 0));
      pending_requests.push_back(make_req(REQ_PUSH, 15, 7, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_ALPHA, 5, 0, 0, 0, 8'h80));
      pending_requests.push_back(make_req(REQ_PUSH, 5, 7, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_DRAW, 15, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_WRITE, 0, 0, 0, 8'h3c, 0));
      pending_requests.push_back(make_req(REQ_ALPHA, 15, 0, 0, 0, 8'hff));
      pending_requests.push_back(make_req(REQ_POP, 15, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_ALPHA, 0, 0, 0, 0, 8'h00));
      pending_requests.push_back(make_req(REQ_POP, 5, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_POP, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(3'd5, 1, 0, 0, 0, 0));
      pending_requests.push_back(make_req(3'd7, 15, 7, 7, 8'hff, 8'hff));
      wait_drained();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 20) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 20) : 0;
         n = 112;
         for (int i = 0; i < n; i++) pending_requests.push_back(rand_req());
         if (ph == 2) begin
            while (pending_requests.size() > 56) @(posedge clock);
            hold_sender = 1;
            while (req_tvalid || expected_cells.size() != 0) @(posedge clock);
            hold_sender = 0;
         end
         wait_drained();
      end
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
